// ----- src/teq_pkg.sv -----
// Shared types and constants for the timestamp event queue.
package teq_pkg;

   localparam int DEF_QUEUE_DEPTH  = 64;
   localparam int DEF_TIME_BITS    = 32;
   localparam int DEF_PROCESS_BITS = 8;

   localparam int STATE_BITS = 3;
   localparam int TRANS_BITS = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_kind_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic ins;
      logic pop;
   } cell_ctl_type;

endpackage

// ----- src/teq_if.sv -----
// Request and response channel interfaces of the timestamp event queue.
interface teq_req_if
   import teq_pkg::*;
#(
   parameter int TIME_BITS    = DEF_TIME_BITS,
   parameter int PROCESS_BITS = DEF_PROCESS_BITS
);
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [TIME_BITS-1:0]    event_time;
   logic [PROCESS_BITS-1:0] process_id;
   logic [STATE_BITS-1:0]   old_state;
   logic [STATE_BITS-1:0]   new_state;
   logic [TRANS_BITS-1:0]   transition;

   modport source (output valid, kind, event_time, process_id, old_state, new_state,
                   transition, input ready);
   modport sink   (input valid, kind, event_time, process_id, old_state, new_state,
                   transition, output ready);
endinterface

interface teq_rsp_if
   import teq_pkg::*;
#(
   parameter int TIME_BITS    = DEF_TIME_BITS,
   parameter int PROCESS_BITS = DEF_PROCESS_BITS
);
   logic                    valid;
   logic                    ready;
   logic                    popped_valid;
   logic [TIME_BITS-1:0]    popped_time;
   logic [PROCESS_BITS-1:0] popped_process;
   logic [STATE_BITS-1:0]   popped_old_state;
   logic [STATE_BITS-1:0]   popped_new_state;
   logic [TRANS_BITS-1:0]   popped_transition;
   logic [TIME_BITS-1:0]    head_time;
   logic                    queue_empty;
   logic                    overflow;

   modport source (output valid, popped_valid, popped_time, popped_process,
                   popped_old_state, popped_new_state, popped_transition, head_time,
                   queue_empty, overflow, input ready);
   modport sink   (input valid, popped_valid, popped_time, popped_process,
                   popped_old_state, popped_new_state, popped_transition, head_time,
                   queue_empty, overflow, output ready);
endinterface

// ----- src/teq_cell.sv -----
// One slot of the sorted shift-register queue.
module teq_cell
   import teq_pkg::*;
#(
   parameter int TIME_BITS = DEF_TIME_BITS,
   parameter int PAY_BITS  = DEF_PROCESS_BITS + 2 * STATE_BITS + TRANS_BITS
) (
   input  logic                 clock,
   input  cell_ctl_type         ctl,
   input  logic                 occ,
   input  logic [TIME_BITS-1:0] new_time,
   input  logic [PAY_BITS-1:0]  new_pay,
   input  logic                 prev_ge,
   input  logic [TIME_BITS-1:0] prev_time,
   input  logic [PAY_BITS-1:0]  prev_pay,
   input  logic [TIME_BITS-1:0] next_time,
   input  logic [PAY_BITS-1:0]  next_pay,
   output logic                 ge,
   output logic [TIME_BITS-1:0] time_q,
   output logic [PAY_BITS-1:0]  pay_q
);
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [PAY_BITS-1:0]  pay_ff, pay_in;

   // Stored event is at or before the new one: it stays ahead of it.
   assign ge = occ && (new_time >= time_ff);

   always_comb begin
      time_in = time_ff;
      pay_in  = pay_ff;
      if (ctl.pop) begin
         time_in = next_time;
         pay_in  = next_pay;
      end else if (ctl.ins && !ge) begin
         if (prev_ge) begin
            time_in = new_time;
            pay_in  = new_pay;
         end else begin
            time_in = prev_time;
            pay_in  = prev_pay;
         end
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      pay_ff  <= pay_in;
   end

   assign time_q = time_ff;
   assign pay_q  = pay_ff;
endmodule

// ----- src/timestamp_event_queue.sv -----
// Top level of the timestamp-ordered event queue.
//
//  channel  dir  transaction
//  req      in   insert an event (kind 0) or pop the earliest event (kind 1)
//  rsp      out  one result per request: popped event, head time, empty, overflow
//
//  One request per cycle: every cell compares the new time against its own
//  time in parallel and shifts toward or away from its neighbor in the same
//  cycle, so no event has to ripple through the cell row one cell at a time.
//  The result sits in an output register; a new request is taken while the
//  held result is being read, and waits only while rsp is stalled.
//  Synchronous reset empties the queue (occupancy count to zero) at once.
module timestamp_event_queue
   import teq_pkg::*;
#(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int TIME_BITS    = DEF_TIME_BITS,
   parameter int PROCESS_BITS = DEF_PROCESS_BITS
) (
   input  logic clock,
   input  logic reset,
   teq_req_if.sink   req_chan,
   teq_rsp_if.source rsp_chan
);
   localparam int PAY_BITS = PROCESS_BITS + 2 * STATE_BITS + TRANS_BITS;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // cell row wiring
   logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
   logic [PAY_BITS-1:0]  cell_pay  [QUEUE_DEPTH];
   logic                 cell_ge   [QUEUE_DEPTH];
   logic                 cell_occ  [QUEUE_DEPTH];

   logic [CNT_BITS-1:0] count_ff, count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_popped_valid_ff, rsp_popped_valid_in;
   logic [TIME_BITS-1:0] rsp_popped_time_ff, rsp_popped_time_in;
   logic [PAY_BITS-1:0]  rsp_popped_pay_ff, rsp_popped_pay_in;
   logic [TIME_BITS-1:0] rsp_head_time_ff, rsp_head_time_in;
   logic rsp_empty_ff, rsp_empty_in;
   logic rsp_overflow_ff, rsp_overflow_in;

   logic           fire, is_pop, q_empty, q_full;
   cell_ctl_type   ctl;
   logic [PAY_BITS-1:0] new_pay;

   assign new_pay = {req_chan.process_id, req_chan.old_state, req_chan.new_state,
                     req_chan.transition};

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));

   // output register frees up when empty or being drained this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire    = req_chan.valid && req_chan.ready;
   assign is_pop  = (req_chan.kind == OP_POP);
   assign ctl.ins = fire && !is_pop && !q_full;
   assign ctl.pop = fire && is_pop && !q_empty;

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) count_in = count_ff + CNT_BITS'(1);
      else if (ctl.pop) count_in = count_ff - CNT_BITS'(1);
   end

   generate
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         localparam int PREV = (i == 0) ? 0 : i - 1;
         localparam int NEXT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

         assign cell_occ[i] = (CNT_BITS'(i) < count_ff);

         teq_cell #(
            .TIME_BITS (TIME_BITS),
            .PAY_BITS  (PAY_BITS)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occ       (cell_occ[i]),
            .new_time  (req_chan.event_time),
            .new_pay   (new_pay),
            .prev_ge   ((i == 0) ? 1'b1 : cell_ge[PREV]),
            .prev_time (cell_time[PREV]),
            .prev_pay  (cell_pay[PREV]),
            .next_time (cell_time[NEXT]),
            .next_pay  (cell_pay[NEXT]),
            .ge        (cell_ge[i]),
            .time_q    (cell_time[i]),
            .pay_q     (cell_pay[i])
         );
      end
   endgenerate

   // result of the transaction, reflecting the queue after it
   always_comb begin
      rsp_popped_valid_in = ctl.pop;
      rsp_popped_time_in  = ctl.pop ? cell_time[0] : '0;
      rsp_popped_pay_in   = ctl.pop ? cell_pay[0] : '0;
      rsp_overflow_in     = fire && !is_pop && q_full;
      rsp_empty_in        = (count_in == '0);
      if (ctl.pop) begin
         rsp_head_time_in = (count_ff > CNT_BITS'(1)) ? cell_time[1] : '0;
      end else if (ctl.ins) begin
         // new event becomes the head unless the current head is at or before it
         rsp_head_time_in = cell_ge[0] ? cell_time[0] : req_chan.event_time;
      end else begin
         rsp_head_time_in = q_empty ? '0 : cell_time[0];
      end
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_popped_valid_ff <= rsp_popped_valid_in;
         rsp_popped_time_ff  <= rsp_popped_time_in;
         rsp_popped_pay_ff   <= rsp_popped_pay_in;
         rsp_head_time_ff    <= rsp_head_time_in;
         rsp_empty_ff        <= rsp_empty_in;
         rsp_overflow_ff     <= rsp_overflow_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.popped_valid      = rsp_popped_valid_ff;
   assign rsp_chan.popped_time       = rsp_popped_time_ff;
   assign rsp_chan.popped_process    =
      rsp_popped_pay_ff[PAY_BITS-1 -: PROCESS_BITS];
   assign rsp_chan.popped_old_state  =
      rsp_popped_pay_ff[2*STATE_BITS+TRANS_BITS-1 -: STATE_BITS];
   assign rsp_chan.popped_new_state  =
      rsp_popped_pay_ff[STATE_BITS+TRANS_BITS-1 -: STATE_BITS];
   assign rsp_chan.popped_transition = rsp_popped_pay_ff[TRANS_BITS-1:0];
   assign rsp_chan.head_time         = rsp_head_time_ff;
   assign rsp_chan.queue_empty       = rsp_empty_ff;
   assign rsp_chan.overflow          = rsp_overflow_ff;

   // ---- assertions ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("occupancy count beyond queue depth");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |=> (count_ff == $past(count_ff) - CNT_BITS'(1)))
      else $error("pop did not shrink the queue by one");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_overflow_ff && rsp_popped_valid_ff))
      else $error("overflow and popped event in one result");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_head_time_ff == '0))
      else $error("empty queue reported a nonzero head time");
endmodule
